FILE: src/sliding_window_aggregate_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the sliding window aggregate
// Implication checks on the rising clock, disabled while reset is asserted.
// -----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AGGREGATE_ASSERT_SVH
`define SLIDING_WINDOW_AGGREGATE_ASSERT_SVH

// same-cycle implication
`define SWA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("swa: same-cycle implication failed");

// next-cycle implication
`define SWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("swa: next-cycle implication failed");

`endif

FILE: src/swa_pkg.sv
// -----------------------------------------------------------------------------
// swa_pkg
// Shared constants and types for the sliding window aggregate.
// -----------------------------------------------------------------------------
package swa_pkg;

    localparam int WINDOW_MAX = 16;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 5;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int ADDR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int ITER_W     = $clog2(DATA_W);

    typedef enum logic [OP_W-1:0] {
        OP_AVG = 2'd0,
        OP_SUM = 2'd1,
        OP_MIN = 2'd2,
        OP_MAX = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN = 1'b0,
        CFG_OPERATION  = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] dividend;
        logic [CNT_W-1:0]         divisor;
    } div_req_t;

endpackage

FILE: src/swa_ram.sv
// -----------------------------------------------------------------------------
// swa_ram
// Simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module swa_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/swa_div.sv
// -----------------------------------------------------------------------------
// swa_div
// Signed by unsigned divider, restoring, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module swa_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  swa_pkg::div_req_t                req,
    output logic                             done,
    output logic signed [swa_pkg::DATA_W-1:0] quotient
);
    import swa_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [ITER_W-1:0] bit_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;
    logic [DATA_W-1:0] magnitude;

    assign trial     = {rem_reg, quo_reg[DATA_W-1]};
    assign ge        = trial >= {1'b0, req.divisor};
    assign diff      = trial - {1'b0, req.divisor};
    // |most negative| still fits as unsigned
    assign magnitude = req.dividend[DATA_W-1] ? (DATA_W'(0) - DATA_W'(req.dividend))
                                              : DATA_W'(req.dividend);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == ITER_W'(DATA_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= magnitude;
            rem_reg <= '0;
            bit_reg <= '0;
            neg_reg <= req.dividend[DATA_W-1];
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DATA_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            bit_reg <= bit_reg + ITER_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(DATA_W'(0) - quo_reg) : $signed(quo_reg);

endmodule

FILE: src/sliding_window_aggregate.sv
// -----------------------------------------------------------------------------
// sliding_window_aggregate: one result per sample, over a window of at most 16 samples;
// the average also runs the divider, and an empty window skips the walk and gives zero.
// One sample in flight; the RAM read port walks one stored sample per cycle, the divider one bit.
// Synchronous active-low reset: window_len 1, average, history empty, output idle.
// -----------------------------------------------------------------------------
module sliding_window_aggregate (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input sample channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [swa_pkg::DATA_W-1:0]    s_sample,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [swa_pkg::DATA_W-1:0]    m_aggregate,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [swa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [swa_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import swa_pkg::*;

    `include "sliding_window_aggregate_assert.svh"

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,  // waiting for a sample transfer
        ST_WALK = 4'b0010,  // reading the window out of the ring, newest first
        ST_DIV  = 4'b0100,  // average: divider running
        ST_DONE = 4'b1000   // hand result to output register, store sample
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [LEN_W-1:0] win_len_reg;
    op_t              op_reg;

    // per-item working registers
    logic signed [DATA_W-1:0] sample_reg, sample_next;
    logic [CNT_W-1:0]         span_reg, span_next;
    logic [CNT_W-1:0]         iss_reg, iss_next;     // reads issued
    logic [CNT_W-1:0]         rcv_reg, rcv_next;     // read data consumed
    logic [ADDR_W-1:0]        rd_slot_reg, rd_slot_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic [DATA_W-1:0]        acc_reg, acc_next;     // wrapping sum
    logic signed [DATA_W-1:0] best_reg, best_next;   // running min or max
    logic signed [DATA_W-1:0] res_reg, res_next;

    // ring bookkeeping
    logic [ADDR_W-1:0] wr_slot_reg, wr_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_agg_reg, m_agg_next;

    // RAM and divider hookup
    logic                     ram_we;
    logic                     ram_re;
    logic signed [DATA_W-1:0] ram_rdata;
    div_req_t                 div_req;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quo;

    // span = min(window_len, WINDOW_MAX, count)
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_lim;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] span_ext;

    logic s_xfer;
    logic out_free;
    logic issue;
    logic walk_end;

    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign issue    = (state_reg == ST_WALK) && (iss_reg != span_reg);
    assign walk_end = (state_reg == ST_WALK) && (rcv_reg == span_reg);

    assign len_ext  = CMP_W'(win_len_reg);
    assign len_lim  = (len_ext > CMP_W'(WINDOW_MAX)) ? CMP_W'(WINDOW_MAX) : len_ext;
    assign cnt_ext  = CMP_W'(count_reg);
    assign span_ext = (len_lim > cnt_ext) ? cnt_ext : len_lim;

    // Configuration decode; the user must write only while idle, the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= LEN_W'(1);
            op_reg      <= OP_AVG;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WINDOW_LEN: win_len_reg <= cfg_wdata[LEN_W-1:0];
                CFG_OPERATION:  op_reg      <= op_t'(cfg_wdata[OP_W-1:0]);
                default: ;
            endcase
        end
    end

    // History ring
    swa_ram #(
        .DEPTH  (WINDOW_MAX),
        .WIDTH  (DATA_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (wr_slot_reg),
        .wdata  (sample_reg),
        .re     (ram_re),
        .raddr  (rd_slot_reg),
        .rdata  (ram_rdata)
    );

    assign ram_re = issue;
    // The new sample is stored only after the walk, so the oldest slot of a
    // full window is read before it is overwritten.
    assign ram_we = (state_reg == ST_DONE) && out_free;

    // Average divider
    assign div_req.start    = walk_end && (op_reg == OP_AVG);
    assign div_req.dividend = $signed(acc_reg);
    assign div_req.divisor  = span_reg;

    swa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer and datapath
    always_comb begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        span_next    = span_reg;
        iss_next     = iss_reg;
        rcv_next     = rcv_reg;
        rd_slot_next = rd_slot_reg;
        rd_pend_next = 1'b0;
        acc_next     = acc_reg;
        best_next    = best_reg;
        res_next     = res_reg;
        wr_slot_next = wr_slot_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_agg_next   = m_agg_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    sample_next  = s_sample;
                    span_next    = span_ext[CNT_W-1:0];
                    iss_next     = '0;
                    rcv_next     = '0;
                    acc_next     = '0;
                    // newest sample sits one slot behind the write pointer
                    rd_slot_next = (wr_slot_reg == '0) ? ADDR_W'(WINDOW_MAX - 1)
                                                       : wr_slot_reg - ADDR_W'(1);
                    if (span_ext == '0) begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                if (issue) begin
                    iss_next     = iss_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                    rd_slot_next = (rd_slot_reg == '0) ? ADDR_W'(WINDOW_MAX - 1)
                                                       : rd_slot_reg - ADDR_W'(1);
                end
                if (rd_pend_reg) begin
                    acc_next = acc_reg + DATA_W'(ram_rdata);
                    rcv_next = rcv_reg + CNT_W'(1);
                    if (rcv_reg == '0) begin
                        best_next = ram_rdata;
                    end else if (op_reg == OP_MIN && ram_rdata < best_reg) begin
                        best_next = ram_rdata;
                    end else if (op_reg == OP_MAX && ram_rdata > best_reg) begin
                        best_next = ram_rdata;
                    end
                end
                if (walk_end) begin
                    case (op_reg)
                        OP_AVG: state_next = ST_DIV;
                        OP_SUM: begin
                            res_next   = $signed(acc_reg);
                            state_next = ST_DONE;
                        end
                        default: begin
                            res_next   = best_reg;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_DIV: begin
                if (div_done) begin
                    res_next   = div_quo;
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_agg_next   = res_reg;
                    wr_slot_next = (wr_slot_reg == ADDR_W'(WINDOW_MAX - 1))
                                   ? '0 : wr_slot_reg + ADDR_W'(1);
                    if (count_reg != CNT_W'(WINDOW_MAX)) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            wr_slot_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            wr_slot_reg <= wr_slot_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        span_reg    <= span_next;
        iss_reg     <= iss_next;
        rcv_reg     <= rcv_next;
        rd_slot_reg <= rd_slot_next;
        acc_reg     <= acc_next;
        best_reg    <= best_next;
        res_reg     <= res_next;
        m_agg_reg   <= m_agg_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_aggregate = m_agg_reg;

    // read data only comes back during the walk
    `SWA_ASSERT_IMPL(a_rd_in_walk, aclk, aresetn, rd_pend_reg, state_reg == ST_WALK)
    // divider finishes only while the sequencer waits for it
    `SWA_ASSERT_IMPL(a_div_in_div, aclk, aresetn, div_done, state_reg == ST_DIV)
    // fill count saturates at the ring depth
    `SWA_ASSERT_IMPL(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_W'(WINDOW_MAX))
    // one sample at a time
    `SWA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_xfer, !s_ready)
    // never consume more reads than the window holds
    `SWA_ASSERT_IMPL(a_rcv_bound, aclk, aresetn, state_reg == ST_WALK, rcv_reg <= span_reg)

endmodule
